// ===== rtl/htw_pkg.sv =====
// ----------------------------------------------------------------------------
// htw_pkg
// Types and codes shared by the hashed timing wheel modules.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int TIMEOUT_W = 16;
    localparam int HANDLE_W  = 6;
    localparam int TAG_W     = 16;
    localparam int KIND_W    = 3;
    localparam int TICKS_W   = 16;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED    = 3'd0,
        KIND_NEGATIVE = 3'd1,
        KIND_FULL     = 3'd2,
        KIND_DELETED  = 3'd3,
        KIND_NOTFOUND = 3'd4,
        KIND_EXPIRED  = 3'd5,
        KIND_IDLE     = 3'd6
    } kind_t;

    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [TIMEOUT_W-1:0] timeout;
        logic [HANDLE_W-1:0]         timer_handle;
        logic [TAG_W-1:0]            user_tag;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle_out;
        logic [TAG_W-1:0]    tag_out;
        logic                last;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// ===== rtl/htw_div.sv =====
// ----------------------------------------------------------------------------
// htw_div
// Restoring divider, one quotient bit per cycle, for timeout / tick_seconds.
// ----------------------------------------------------------------------------
module htw_div
    import htw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [TICKS_W-1:0] dividend,
    input  logic [7:0]         divisor,
    output div_ctl_t           ctl,
    output logic [TICKS_W-1:0] quotient
);

    logic [TICKS_W-1:0] q_reg;
    logic [8:0]         rem_reg;
    logic [7:0]         dvs_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [8:0]         shifted;
    logic [9:0]         diff;

    always_comb begin
        shifted = {rem_reg[7:0], q_reg[TICKS_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(TICKS_W);
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (diff[9]) begin
                    rem_reg <= shifted;
                    q_reg   <= {q_reg[TICKS_W-2:0], 1'b0};
                end else begin
                    rem_reg <= diff[8:0];
                    q_reg   <= {q_reg[TICKS_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = q_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

endmodule

// ===== rtl/hashed_timing_wheel.sv =====
// ----------------------------------------------------------------------------
// hashed_timing_wheel
// Timer wheel: slot heads and the entry pool in synchronous memories,
// walked by one sequencer.
// ----------------------------------------------------------------------------
// Add: a negative timeout is answered at once; else divide, scan the pool for a
// free entry (full pool: full), link it at the slot head, relink the old head.
// Delete: unlink and relink a successor; an unknown handle is answered at once.
// Tick: walk the slot list, counting down rounds or unlinking each expiry.
// One word in flight: the next is taken the cycle after the last result leaves.
// After reset a clear pass empties each of the SLOT_COUNT slot heads first.
module hashed_timing_wheel
    import htw_pkg::*;
#(
    parameter int POOL_DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LW = PW + 1;
    localparam logic [LW-1:0] NIL = {LW{1'b1}};

    typedef struct packed {
        logic [SW-1:0]    slot;
        logic [TICKS_W-1:0] rounds;
        logic [TAG_W-1:0] tag;
        logic [LW-1:0]    nxt;
        logic [LW-1:0]    prv;
    } entry_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DIV, S_SCAN, S_ADD_RD, S_ADD_WR, S_ADD_OLD, S_ADD_LNK,
        S_DEL_RD, S_DEL_HD, S_UNL_PV, S_UNL_NX, S_UNL_NXW, S_TK_HD, S_TK_RD,
        S_TK_ACT, S_OUT
    } state_t;

    state_t state_reg;

    // memories
    logic [LW-1:0] head_mem [SLOT_COUNT];
    entry_t        ent_mem  [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] valid_reg;

    logic          h_we;
    logic [SW-1:0] h_addr;
    logic [LW-1:0] h_wd, h_rd;
    logic          e_we;
    logic [PW-1:0] e_addr;
    entry_t        e_wd, e_rd;

    always_ff @(posedge aclk) begin
        if (h_we) head_mem[h_addr] <= h_wd;
        h_rd <= head_mem[h_addr];
    end

    always_ff @(posedge aclk) begin
        if (e_we) ent_mem[e_addr] <= e_wd;
        e_rd <= ent_mem[e_addr];
    end

    logic [7:0]    tick_sec_reg;
    logic [SW-1:0] cur_reg;
    logic [SW:0]   clr_reg;
    in_word_t      in_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [SW-1:0] ts_reg;
    logic [PW:0]   scan_reg;
    logic [PW-1:0] ent_reg;
    entry_t        cur_e_reg;
    logic [LW-1:0] walk_reg;
    logic [PW:0]   guard_reg;
    logic          any_reg;
    logic          tick_mode_reg;
    logic          m_valid_reg;
    out_word_t     m_data_reg;
    out_word_t     pend_reg;

    logic          div_start;
    div_ctl_t      div_ctl;
    logic [TICKS_W-1:0] quot;
    logic [7:0]    si;

    assign si = (tick_sec_reg == 8'd0) ? 8'd1 : tick_sec_reg;

    htw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (TICKS_W'(s_data.timeout)),
        .divisor  (si),
        .ctl      (div_ctl),
        .quotient (quot)
    );

    logic [TICKS_W-1:0] ticks_c;
    assign ticks_c = (quot == '0) ? TICKS_W'(1) : quot;

    assign s_ready   = (state_reg == S_IDLE) && !m_valid_reg;
    assign div_start = s_ready && s_valid && (s_data.mode == MODE_ADD)
                       && !s_data.timeout[TIMEOUT_W-1];
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    logic [SW-1:0] e_slot;
    assign e_slot = e_rd.slot;

    // memory port control
    always_comb begin
        h_we   = 1'b0;
        h_addr = cur_reg;
        h_wd   = NIL;
        e_we   = 1'b0;
        e_addr = ent_reg;
        e_wd   = cur_e_reg;
        unique case (state_reg)
            S_CLEAR: begin
                h_we   = 1'b1;
                h_addr = clr_reg[SW-1:0];
            end
            S_SCAN:   h_addr = ts_reg;
            S_ADD_WR: begin
                h_addr = ts_reg;
                h_we   = 1'b1;
                h_wd   = LW'(ent_reg);
                e_we   = 1'b1;
                e_wd   = '{slot: ts_reg, rounds: ticks_reg >> SW,
                           tag: in_reg.user_tag, nxt: h_rd, prv: NIL};
            end
            S_ADD_OLD: e_addr = cur_e_reg.nxt[PW-1:0];
            S_ADD_LNK: begin
                e_addr = cur_e_reg.nxt[PW-1:0];
                e_we   = 1'b1;
                e_wd   = e_rd;
                e_wd.prv = LW'(ent_reg);
            end
            S_DEL_HD: h_addr = e_slot;
            S_UNL_PV: begin
                h_addr = cur_e_reg.slot;
                e_addr = cur_e_reg.prv[PW-1:0];
                if (h_rd == LW'(ent_reg)) begin
                    h_we = 1'b1;
                    h_wd = cur_e_reg.nxt;
                end
            end
            S_UNL_NX: begin
                h_addr = cur_e_reg.slot;
                e_addr = cur_e_reg.prv[PW-1:0];
                if (h_rd != LW'(ent_reg) && cur_e_reg.prv != NIL) begin
                    e_we = 1'b1;
                    e_wd = e_rd;
                    e_wd.nxt = cur_e_reg.nxt;
                end
            end
            S_UNL_NXW: begin
                h_addr = cur_e_reg.slot;
                e_addr = cur_e_reg.nxt[PW-1:0];
            end
            S_OUT: begin
                h_addr = cur_e_reg.slot;
                e_addr = cur_e_reg.nxt[PW-1:0];
                e_we   = 1'b1;
                e_wd   = e_rd;
                e_wd.prv = (h_rd == cur_e_reg.nxt) ? NIL : cur_e_reg.prv;
            end
            S_TK_RD:  e_addr = walk_reg[PW-1:0];
            S_TK_ACT: begin
                e_addr = ent_reg;
                if (e_rd.rounds != '0) begin
                    e_we = 1'b1;
                    e_wd = e_rd;
                    e_wd.rounds = e_rd.rounds - TICKS_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            tick_sec_reg <= 8'd1;
            cur_reg      <= '0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) tick_sec_reg <= cfg_wdata;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (SW+1)'(SLOT_COUNT - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        in_reg <= s_data;
                        unique case (mode_t'(s_data.mode))
                            MODE_ADD: begin
                                if (s_data.timeout[TIMEOUT_W-1]) begin
                                    m_data_reg  <= '{KIND_NEGATIVE, '0, '0, 1'b1};
                                    m_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= S_DIV;
                                end
                            end
                            MODE_DEL: begin
                                ent_reg <= s_data.timer_handle[PW-1:0];
                                if (32'(s_data.timer_handle) < POOL_DEPTH
                                    && valid_reg[s_data.timer_handle[PW-1:0]]) begin
                                    state_reg <= S_DEL_RD;
                                end else begin
                                    m_data_reg  <= '{KIND_NOTFOUND,
                                                    s_data.timer_handle, '0, 1'b1};
                                    m_valid_reg <= 1'b1;
                                end
                            end
                            MODE_TICK: begin
                                any_reg   <= 1'b0;
                                guard_reg <= '0;
                                state_reg <= S_TK_HD;
                            end
                            MODE_NONE: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_ctl.done) begin
                        ticks_reg <= ticks_c;
                        ts_reg    <= SW'(cur_reg + SW'(ticks_c));
                        scan_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_reg == (PW+1)'(POOL_DEPTH)) begin
                        m_data_reg  <= '{KIND_FULL, '0, '0, 1'b1};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end else if (!valid_reg[scan_reg[PW-1:0]]) begin
                        ent_reg   <= scan_reg[PW-1:0];
                        state_reg <= S_ADD_WR;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_ADD_WR: begin
                    valid_reg[ent_reg] <= 1'b1;
                    cur_e_reg.nxt <= h_rd;
                    m_data_reg    <= '{KIND_ADDED, HANDLE_W'(ent_reg), '0, 1'b1};
                    if (h_rd != NIL) state_reg <= S_ADD_OLD;
                    else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_ADD_OLD: state_reg <= S_ADD_LNK;
                S_ADD_LNK: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                S_DEL_RD: begin
                    tick_mode_reg <= 1'b0;
                    state_reg     <= S_DEL_HD;
                end
                S_DEL_HD: begin
                    cur_e_reg <= e_rd;
                    state_reg <= S_UNL_PV;
                end
                S_UNL_PV: state_reg <= S_UNL_NX;
                S_UNL_NX: state_reg <= S_UNL_NXW;
                S_UNL_NXW: begin
                    valid_reg[ent_reg] <= 1'b0;
                    if (!tick_mode_reg) begin
                        m_data_reg  <= '{KIND_DELETED, HANDLE_W'(ent_reg),
                                        cur_e_reg.tag, 1'b1};
                        m_valid_reg <= 1'b1;
                    end
                    if (cur_e_reg.nxt != NIL) state_reg <= S_OUT;
                    else if (tick_mode_reg) state_reg <= S_TK_RD;
                    else state_reg <= S_IDLE;
                end
                S_OUT: begin
                    // fix next entry's back link: prv = nil if it is now head
                    if (tick_mode_reg) state_reg <= S_TK_RD;
                    else state_reg <= S_IDLE;
                end
                S_TK_HD: begin
                    walk_reg  <= h_rd;
                    state_reg <= S_TK_RD;
                end
                S_TK_RD: begin
                    if (m_valid_reg && !m_ready) begin
                        state_reg <= S_TK_RD;
                    end else if (walk_reg != NIL && 32'(walk_reg) < POOL_DEPTH
                                 && guard_reg != (PW+1)'(POOL_DEPTH)) begin
                        ent_reg   <= walk_reg[PW-1:0];
                        guard_reg <= guard_reg + 1'b1;
                        state_reg <= S_TK_ACT;
                    end else begin
                        if (any_reg) begin
                            m_data_reg <= '{KIND_EXPIRED, pend_reg.handle_out,
                                           pend_reg.tag_out, 1'b1};
                        end else begin
                            m_data_reg <= '{KIND_IDLE, '0, '0, 1'b1};
                        end
                        m_valid_reg <= 1'b1;
                        cur_reg   <= cur_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_TK_ACT: begin
                    walk_reg <= e_rd.nxt;
                    if (e_rd.rounds != '0) begin
                        state_reg <= S_TK_RD;
                    end else begin
                        any_reg       <= 1'b1;
                        tick_mode_reg <= 1'b1;
                        cur_e_reg     <= e_rd;
                        pend_reg      <= '{KIND_EXPIRED, HANDLE_W'(ent_reg),
                                          e_rd.tag, 1'b0};
                        if (any_reg) begin
                            m_data_reg  <= pend_reg;
                            m_valid_reg <= 1'b1;
                        end
                        state_reg     <= S_UNL_PV;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data));
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid);
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready);
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.done |-> state_reg == S_DIV);

endmodule
